// File: rtl/ipv4c_pkg.sv
// Shared types for the dotted-decimal IPv4 text classifier.
`default_nettype none
package ipv4c_pkg;

    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharNine = 8'h39;
    localparam logic [7:0] CharDot  = 8'h2e;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_t;

    typedef struct packed {
        logic       valid_ipv4;
        logic       private_addr;
        logic       public_addr;
    } out_t;

    typedef struct packed {
        logic       well_formed;
        logic [7:0] octet0;
        logic [7:0] octet1;
        logic [7:0] octet2;
        logic [7:0] octet3;
        logic [3:1] single_digit;
    } snap_t;

endpackage
`default_nettype wire

// File: rtl/ipv4_text_address_classifier.sv
// Top level of the dotted-decimal IPv4 text classifier.
// Takes one address character per transaction, with last set on the final character,
// and returns one result transaction per address (valid_ipv4, private_addr, public_addr)
// in the cycle after the final character is accepted. Throughput is one character per
// cycle: parser state is registered per accepted character and the result sits in an
// output register, so in_ready stays high unless a result is held by out_ready low.
// Private covers 10/8, 172.16/12, 192.168/16 and the exact text 127.0.0.1.
`default_nettype none
module ipv4_text_address_classifier (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ipv4c_pkg::in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ipv4c_pkg::out_t      out_data
);
    import ipv4c_pkg::*;

    logic  take;
    snap_t snap;
    out_t  flags;
    logic  out_valid_reg, out_valid_next;
    out_t  out_data_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    ipv4c_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_item (in_data),
        .snap    (snap)
    );

    ipv4c_class u_class (
        .snap  (snap),
        .flags (flags)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (take && in_data.last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_data.last)
        begin
            out_data_reg <= flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// File: rtl/ipv4c_scan.sv
// Per-character parser state: octet accumulation, dot counting and error tracking.
`default_nettype none
module ipv4c_scan (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           take,
    input  wire ipv4c_pkg::in_t in_item,
    output ipv4c_pkg::snap_t    snap
);
    import ipv4c_pkg::*;

    logic [1:0]       field_index_reg, field_index_next, fi_upd;
    logic [1:0]       digit_count_reg, digit_count_next, dc_upd;
    logic [9:0]       octet_accum_reg, octet_accum_next, acc_upd;
    logic [3:0][7:0]  octet_values_reg, octet_values_next, oct_upd;
    logic [3:0]       marks_reg, marks_next, marks_upd;
    logic             error_seen_reg, error_seen_next, err_upd;
    logic             is_digit;
    logic             is_dot;
    logic [3:0]       digit_val;

    function automatic logic octet_ok(input logic [1:0] dc, input logic [9:0] acc);
        octet_ok = (dc != 2'd0) && !((dc == 2'd3) && ((acc < 10'd100) || (acc > 10'd255)));
    endfunction

    assign is_digit  = (in_item.ch >= CharZero) && (in_item.ch <= CharNine);
    assign is_dot    = (in_item.ch == CharDot);
    assign digit_val = 4'(in_item.ch - CharZero);

    always_comb
    begin
        fi_upd    = field_index_reg;
        dc_upd    = digit_count_reg;
        acc_upd   = octet_accum_reg;
        oct_upd   = octet_values_reg;
        marks_upd = marks_reg;
        err_upd   = error_seen_reg;
        if (!error_seen_reg)
        begin
            if (is_digit)
            begin
                if (digit_count_reg == 2'd3)
                begin
                    err_upd = 1'b1;
                end
                else
                begin
                    acc_upd = 10'((octet_accum_reg << 3) + (octet_accum_reg << 1)
                                  + {6'd0, digit_val});
                    dc_upd  = digit_count_reg + 2'd1;
                end
            end
            else if (is_dot)
            begin
                if ((field_index_reg == 2'd3) || !octet_ok(digit_count_reg, octet_accum_reg))
                begin
                    err_upd = 1'b1;
                end
                else
                begin
                    oct_upd[field_index_reg] = octet_accum_reg[7:0];
                    if (digit_count_reg == 2'd1)
                    begin
                        marks_upd[field_index_reg] = 1'b1;
                    end
                    dc_upd  = 2'd0;
                    acc_upd = 10'd0;
                    fi_upd  = field_index_reg + 2'd1;
                end
            end
            else
            begin
                err_upd = 1'b1;
            end
        end
    end

    always_comb
    begin
        snap.well_formed  = !err_upd && (fi_upd == 2'd3) && octet_ok(dc_upd, acc_upd);
        snap.octet0       = oct_upd[0];
        snap.octet1       = oct_upd[1];
        snap.octet2       = oct_upd[2];
        snap.octet3       = acc_upd[7:0];
        snap.single_digit = {dc_upd == 2'd1, marks_upd[2:1]};
    end

    always_comb
    begin
        if (in_item.last)
        begin
            field_index_next  = '0;
            digit_count_next  = '0;
            octet_accum_next  = '0;
            octet_values_next = '0;
            marks_next        = '0;
            error_seen_next   = 1'b0;
        end
        else
        begin
            field_index_next  = fi_upd;
            digit_count_next  = dc_upd;
            octet_accum_next  = acc_upd;
            octet_values_next = oct_upd;
            marks_next        = marks_upd;
            error_seen_next   = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg  <= '0;
            digit_count_reg  <= '0;
            octet_accum_reg  <= '0;
            octet_values_reg <= '0;
            marks_reg        <= '0;
            error_seen_reg   <= 1'b0;
        end
        else if (take)
        begin
            field_index_reg  <= field_index_next;
            digit_count_reg  <= digit_count_next;
            octet_accum_reg  <= octet_accum_next;
            octet_values_reg <= octet_values_next;
            marks_reg        <= marks_next;
            error_seen_reg   <= error_seen_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/ipv4c_class.sv
// Range classification of a completed address into valid, private and public flags.
`default_nettype none
module ipv4c_class (
    input  wire ipv4c_pkg::snap_t snap,
    output ipv4c_pkg::out_t       flags
);
    import ipv4c_pkg::*;

    logic priv;

    always_comb
    begin
        priv = 1'b0;
        if (snap.octet0 == 8'd10)
        begin
            priv = 1'b1;
        end
        else if ((snap.octet0 == 8'd172) && (snap.octet1 >= 8'd16) && (snap.octet1 <= 8'd31))
        begin
            priv = 1'b1;
        end
        else if ((snap.octet0 == 8'd192) && (snap.octet1 == 8'd168))
        begin
            priv = 1'b1;
        end
        else if ((snap.octet0 == 8'd127) && (snap.octet1 == 8'd0) && (snap.octet2 == 8'd0)
                 && (snap.octet3 == 8'd1) && (snap.single_digit == 3'b111))
        begin
            priv = 1'b1;
        end
        flags.valid_ipv4   = snap.well_formed;
        flags.private_addr = snap.well_formed && priv;
        flags.public_addr  = snap.well_formed && !priv;
    end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for the dotted-decimal IPv4 text classifier.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4c_pkg::*;

    localparam int RandomChars = 1100;
    localparam int LongHoldCycles = 300;

    localparam int FlawNone       = 0;
    localparam int FlawEmptyOctet = 1;
    localparam int FlawLongOctet  = 2;
    localparam int FlawBadValue   = 3;
    localparam int FlawStrayByte  = 4;
    localparam int FlawDotCount   = 5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    ipv4_text_address_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    in_t        pending_chars[$];
    out_t       expected_verdicts[$];
    logic [7:0] text_buf[$];
    int         chars_queued = 0;
    int         chars_accepted = 0;
    int         verdicts_checked = 0;
    int         error_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         sender_hold = 1'b0;
    bit         in_took = 1'b0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         rx_hold_left = 0;

    // Predictor state
    logic [1:0] dots_seen;
    logic [1:0] digits_in_octet;
    logic [9:0] octet_sum;
    logic [7:0] octet_val[4];
    logic [3:0] one_digit_octets;
    bit         text_broken;

    function void clear_parser();
        dots_seen        = '0;
        digits_in_octet  = '0;
        octet_sum        = '0;
        octet_val        = '{default: '0};
        one_digit_octets = '0;
        text_broken      = 1'b0;
    endfunction

    function bit close_octet();
        if (digits_in_octet == 2'd0)
            return 1'b0;
        if (digits_in_octet == 2'd3 && (octet_sum < 10'd100 || octet_sum > 10'd255))
            return 1'b0;
        octet_val[dots_seen] = octet_sum[7:0];
        if (digits_in_octet == 2'd1)
            one_digit_octets[dots_seen] = 1'b1;
        digits_in_octet = '0;
        octet_sum = '0;
        return 1'b1;
    endfunction

    function void classify_char(in_t item);
        bit   well_formed;
        bit   addr_private;
        out_t verdict;
        if (!text_broken)
        begin
            if (item.ch >= CharZero && item.ch <= CharNine)
            begin
                if (digits_in_octet == 2'd3)
                    text_broken = 1'b1;
                else
                begin
                    octet_sum = octet_sum * 10'd10 + 10'(item.ch - CharZero);
                    digits_in_octet = digits_in_octet + 2'd1;
                end
            end
            else if (item.ch == CharDot)
            begin
                if (dots_seen == 2'd3)
                    text_broken = 1'b1;
                else if (!close_octet())
                    text_broken = 1'b1;
                else
                    dots_seen = dots_seen + 2'd1;
            end
            else
                text_broken = 1'b1;
        end
        if (item.last)
        begin
            well_formed = 1'b0;
            if (!text_broken && dots_seen == 2'd3)
                well_formed = close_octet();
            addr_private = 1'b0;
            if (well_formed)
            begin
                if (octet_val[0] == 8'd10)
                    addr_private = 1'b1;
                else if (octet_val[0] == 8'd172 && octet_val[1] >= 8'd16
                         && octet_val[1] <= 8'd31)
                    addr_private = 1'b1;
                else if (octet_val[0] == 8'd192 && octet_val[1] == 8'd168)
                    addr_private = 1'b1;
                else if (octet_val[0] == 8'd127 && octet_val[1] == 8'd0
                         && octet_val[2] == 8'd0 && octet_val[3] == 8'd1
                         && one_digit_octets[3:1] == 3'b111)
                    addr_private = 1'b1;
            end
            verdict.valid_ipv4   = well_formed;
            verdict.private_addr = addr_private;
            verdict.public_addr  = well_formed && !addr_private;
            expected_verdicts.push_back(verdict);
            clear_parser();
        end
    endfunction

    // Text building
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic add_digits(input int v, input int ndig);
        if (ndig >= 3)
            text_buf.push_back(CharZero + 8'((v / 100) % 10));
        if (ndig >= 2)
            text_buf.push_back(CharZero + 8'((v / 10) % 10));
        text_buf.push_back(CharZero + 8'(v % 10));
    endtask

    task automatic commit_text();
        in_t item;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            item.ch   = text_buf[i];
            item.last = (i == text_buf.size() - 1);
            pending_chars.push_back(item);
            chars_queued++;
        end
        text_buf.delete();
    endtask

    task automatic send_text(input string s);
        add_str(s);
        commit_text();
    endtask

    task automatic add_good_octet(input int slot);
        int v;
        int pick;
        pick = $urandom_range(0, 5);
        v = $urandom_range(0, 255);
        if (slot == 0)
        begin
            case (pick)
                0: v = 10;
                1: v = 172;
                2: v = 192;
                3: v = 127;
                default: ;
            endcase
        end
        else if (slot == 1)
        begin
            case (pick)
                0: v = $urandom_range(14, 33);
                1: v = 168;
                2: v = 0;
                default: ;
            endcase
        end
        if (v >= 100)
            add_digits(v, 3);
        else if (v >= 10)
            add_digits(v, 2);
        else
            add_digits(v, $urandom_range(1, 2));
    endtask

    task automatic gen_address(input int flaw);
        int n_oct;
        int bad_slot;
        n_oct = 4;
        if (flaw == FlawDotCount)
            n_oct = ($urandom_range(0, 1) != 0) ? 5 : $urandom_range(1, 3);
        bad_slot = $urandom_range(0, n_oct - 1);
        for (int i = 0; i < n_oct; i++)
        begin
            if (i > 0)
                text_buf.push_back(CharDot);
            if (flaw == FlawNone || flaw == FlawDotCount || i != bad_slot)
                add_good_octet(i);
            else
            begin
                case (flaw)
                    FlawLongOctet: add_digits($urandom_range(0, 9999), 3);
                    FlawBadValue: add_digits(($urandom_range(0, 1) != 0)
                                             ? $urandom_range(0, 99)
                                             : $urandom_range(256, 999), 3);
                    FlawStrayByte:
                    begin
                        add_good_octet(i);
                        text_buf.insert($urandom_range(0, text_buf.size()),
                                        8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
                if (flaw == FlawLongOctet)
                    text_buf.push_back(CharZero + 8'($urandom_range(0, 9)));
            end
        end
        commit_text();
    endtask

    task automatic gen_loopback();
        string variants[6];
        variants = '{"127.0.0.1", "127.00.0.1", "127.0.00.1", "127.0.0.01",
                     "127.0.0.2", "127.1.0.1"};
        if ($urandom_range(0, 1) != 0)
            send_text("127.0.0.1");
        else
            send_text(variants[$urandom_range(0, 5)]);
    endtask

    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            text_buf.push_back(8'($urandom_range(0, 255)));
        commit_text();
    endtask

    task automatic gen_random_chars(input int budget);
        int stop_at;
        int pick;
        stop_at = chars_queued + budget;
        while (chars_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                gen_address(FlawNone);
            else if (pick < 65)
                gen_loopback();
            else if (pick < 88)
                gen_address($urandom_range(FlawEmptyOctet, FlawDotCount));
            else
                gen_noise();
        end
    endtask

    task automatic wait_accepted();
        while (chars_accepted != chars_queued)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        wait_accepted();
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // Driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                in_took = 1'b0;
                if (sender_hold || pending_chars.size() == 0
                    || $urandom_range(0, 99) < send_idle_pct)
                    in_valid <= 1'b0;
                else
                begin
                    in_data  <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_requests)
            begin
                hold_served  = hold_requests;
                rx_hold_left = LongHoldCycles;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                classify_char(in_data);
                chars_accepted++;
                in_took = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                verdicts_checked++;
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result transaction %b", out_data);
                    error_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_data.valid_ipv4 !== want.valid_ipv4)
                    begin
                        $error("valid_ipv4: expected %b, got %b",
                               want.valid_ipv4, out_data.valid_ipv4);
                        error_count++;
                    end
                    if (out_data.private_addr !== want.private_addr)
                    begin
                        $error("private_addr: expected %b, got %b",
                               want.private_addr, out_data.private_addr);
                        error_count++;
                    end
                    if (out_data.public_addr !== want.public_addr)
                    begin
                        $error("public_addr: expected %b, got %b",
                               want.public_addr, out_data.public_addr);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Simulation timed out");
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clear_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed texts
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("10.1.2.3");
        send_text("172.16.0.1");
        send_text("172.31.9.9");
        send_text("172.15.0.1");
        send_text("172.32.0.1");
        send_text("192.168.0.1");
        send_text("192.169.0.1");
        send_text("127.0.0.1");
        send_text("127.00.0.1");
        send_text("127.0.0.01");
        send_text("100.99.09.5");
        send_text("256.1.1.1");
        send_text("099.1.1.1");
        send_text("1234.1.1.1");
        send_text("1..2.3");
        send_text("1.2.3.");
        send_text("1.2.3.4.5");
        send_text("1.2.3");
        send_text("1.2.a.4");
        send_text("10.0.0.1x9");
        send_text(".");
        send_text("9");
        text_buf.push_back(8'hff);
        commit_text();
        text_buf.push_back(8'h00);
        commit_text();
        wait_drained();

        // Receiver held off while the sender keeps offering
        hold_requests++;
        gen_random_chars(150);
        wait_accepted();

        // Sender paused after all results are back
        wait_drained();
        sender_hold = 1'b1;
        repeat (20) @(posedge clk);
        sender_hold = 1'b0;

        send_idle_pct = 0;
        recv_stall_pct = 0;
        gen_random_chars(RandomChars / 4);
        wait_drained();

        send_idle_pct = 68;
        gen_random_chars(RandomChars / 4);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 68;
        gen_random_chars(RandomChars / 4);
        wait_drained();

        send_idle_pct = 35;
        recv_stall_pct = 35;
        gen_random_chars(RandomChars / 4);
        wait_drained();

        repeat (20) @(posedge clk);
        $display("Sent %0d characters, checked %0d address verdicts", chars_accepted,
                 verdicts_checked);
        $display("Covered free-flow, sender idle, receiver stall, mixed and long hold-off");
        if (error_count == 0 && expected_verdicts.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/ipv4c_pkg.sv
rtl/ipv4c_scan.sv
rtl/ipv4c_class.sv
rtl/ipv4_text_address_classifier.sv
dv/tb_top.sv
